// ===== rtl/core/rtfb_pkg.sv =====
`default_nettype none
package rtfb_pkg;

	localparam int PAYLOAD_CAPACITY_DEF = 128;

	localparam logic [7:0] DELIM_BYTE   = 8'h7E;
	localparam logic [7:0] ESC_BYTE     = 8'h7D;
	localparam logic [7:0] XON_BYTE     = 8'h11;
	localparam logic [7:0] XOFF_BYTE    = 8'h13;
	localparam logic [7:0] ESC_XOR      = 8'h20;
	localparam logic [7:0] TX_REQ_TYPE  = 8'h10;
	localparam logic [7:0] CSUM_BASE    = 8'hFF;
	localparam int         HEADER_LEN   = 14;

	localparam int POS_LEN_HI     = 1;
	localparam int POS_LEN_LO     = 2;
	localparam int POS_TYPE       = 3;
	localparam int POS_IDENT      = 4;
	localparam int POS_ADDR_LAST  = 12;
	localparam int POS_SHORT_HI   = 13;
	localparam int POS_SHORT_LO   = 14;
	localparam int POS_RADIUS     = 15;
	localparam int POS_OPTIONS    = 16;
	localparam int PAYLOAD_START  = 17;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_LONG  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_SHORT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ID   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OPTIONS    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 3'd6;

	typedef enum logic [1:0] {
		MODE_BYTE = 2'd0,
		MODE_TICK = 2'd1,
		MODE_PULL = 2'd2
	} mode_t;

	typedef struct packed {
		logic       frame_end;
		logic [7:0] frame_byte;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/rtfb_out_skid.sv =====
`default_nettype none
module rtfb_out_skid (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  wire rtfb_pkg::out_item_t push_item,
	output logic                   room,
	output logic                   out_valid,
	input  wire                    out_ready,
	output rtfb_pkg::out_item_t    out_item
);
	import rtfb_pkg::*;

	logic      out_valid_q;
	logic      skid_valid_q;
	out_item_t out_item_q;
	out_item_t skid_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_item_q  <= skid_item_q;
				skid_item_q <= push_item;
			end else begin
				out_item_q <= push_item;
			end
		end else if (push) begin
			skid_item_q <= push_item;
		end
	end

	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire

// ===== rtl/core/radio_api_tx_frame_builder_top.sv =====
// Throughput: one item per cycle while the output stage has room; bytes, ticks, pulls alike.
// The frame byte of a pull is registered in the output stage before it appears on m_axis.
// A two-entry output stage keeps input accepted while one frame byte waits downstream.
// Payload and transmit buffers are two banks of one memory with a registered read port.
// Reset clears all control state and restores register defaults; buffer contents stay undefined.
`default_nettype none
module radio_api_tx_frame_builder_top #(
	parameter int PAYLOAD_CAPACITY = rtfb_pkg::PAYLOAD_CAPACITY_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [23:0]                        s_axis_tdata,  // byte_value, message_length
	input  wire  [1:0]                         s_axis_tuser,  // mode
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // frame_byte
	output logic                               m_axis_tlast,
	input  wire                                cfg_we,
	input  wire  [rtfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [63:0]                        cfg_data
);
	import rtfb_pkg::*;

	localparam int AW = $clog2(PAYLOAD_CAPACITY);
	localparam int FW = $clog2(PAYLOAD_CAPACITY + 1);
	localparam int PW = $clog2(PAYLOAD_CAPACITY + PAYLOAD_START + 2);
	localparam int MEM_DEPTH = 2 ** (AW + 1);

	logic [63:0] dest_long_q;
	logic [15:0] dest_short_q;
	logic [7:0]  frame_id_q;
	logic [7:0]  radius_q;
	logic [7:0]  options_q;
	logic [15:0] timeout_q;
	logic [7:0]  threshold_q;

	logic [FW-1:0] fill_q, cnt_q;
	logic          bank_q, busy_q, esc_q, acc_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    follow_q, sum_q;
	logic [15:0]   left_q, tick_q;

	logic [FW-1:0] fill_v, cnt_v;
	logic          bank_v, busy_v, esc_v, acc_v, push_v, end_v, we_v;
	logic [PW-1:0] pos_v;
	logic [7:0]    follow_v, sum_v, byte_v;
	logic [15:0]   left_v, tick_v, eff_v;
	logic [AW:0]   wa_v;

	logic [7:0]    mem [MEM_DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW:0]   ra;

	logic          accept, room;
	mode_t         mode;
	logic [7:0]    in_byte;
	logic [15:0]   in_len;
	logic [PW-1:0] last;
	logic [15:0]   frame_len;
	logic [2:0]    addr_sh;
	logic [63:0]   addr_shifted;
	logic [7:0]    raw;
	out_item_t     push_item, out_item;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign mode    = mode_t'(s_axis_tuser);
	assign in_byte = s_axis_tdata[7:0];
	assign in_len  = s_axis_tdata[23:8];
	assign s_axis_tready = room;

	assign last         = PW'(PAYLOAD_START) + PW'(cnt_q);
	assign frame_len    = 16'(HEADER_LEN) + 16'(cnt_q);
	assign addr_sh      = 3'(PW'(POS_ADDR_LAST) - pos_q);
	assign addr_shifted = dest_long_q >> {addr_sh, 3'b000};

	always_comb begin
		if (pos_q == '0) begin
			raw = DELIM_BYTE;
		end else if (pos_q == PW'(POS_LEN_HI)) begin
			raw = frame_len[15:8];
		end else if (pos_q == PW'(POS_LEN_LO)) begin
			raw = frame_len[7:0];
		end else if (pos_q == PW'(POS_TYPE)) begin
			raw = TX_REQ_TYPE;
		end else if (pos_q == PW'(POS_IDENT)) begin
			raw = frame_id_q;
		end else if (pos_q <= PW'(POS_ADDR_LAST)) begin
			raw = addr_shifted[7:0];
		end else if (pos_q == PW'(POS_SHORT_HI)) begin
			raw = dest_short_q[15:8];
		end else if (pos_q == PW'(POS_SHORT_LO)) begin
			raw = dest_short_q[7:0];
		end else if (pos_q == PW'(POS_RADIUS)) begin
			raw = radius_q;
		end else if (pos_q == PW'(POS_OPTIONS)) begin
			raw = options_q;
		end else if (pos_q < last) begin
			raw = rd_data_q;
		end else begin
			raw = CSUM_BASE - sum_q;
		end
	end

	always_comb begin
		fill_v   = fill_q;
		cnt_v    = cnt_q;
		bank_v   = bank_q;
		busy_v   = busy_q;
		esc_v    = esc_q;
		acc_v    = acc_q;
		pos_v    = pos_q;
		follow_v = follow_q;
		sum_v    = sum_q;
		left_v   = left_q;
		tick_v   = tick_q;
		push_v   = 1'b0;
		end_v    = 1'b0;
		byte_v   = raw;
		we_v     = 1'b0;
		eff_v    = (in_len == '0) ? 16'd1 : in_len;
		wa_v     = {bank_q, fill_q[AW-1:0]};
		if (accept) begin
			case (mode)
				MODE_BYTE: begin
					if (left_v == '0) begin
						left_v = eff_v;
						if (fill_v == '0) begin
							tick_v = '0;
						end
						if (left_v >= 16'(PAYLOAD_CAPACITY)) begin
							acc_v = 1'b0;
						end else begin
							if (17'(fill_v) + 17'(left_v) >= 17'(PAYLOAD_CAPACITY) && !busy_v) begin
								bank_v   = !bank_v;
								cnt_v    = fill_v;
								busy_v   = 1'b1;
								pos_v    = '0;
								esc_v    = 1'b0;
								follow_v = '0;
								sum_v    = '0;
								fill_v   = '0;
							end
							acc_v = 17'(fill_v) + 17'(left_v) < 17'(PAYLOAD_CAPACITY);
						end
					end
					if (acc_v && fill_v < FW'(PAYLOAD_CAPACITY)) begin
						we_v   = 1'b1;
						wa_v   = {bank_v, fill_v[AW-1:0]};
						fill_v = fill_v + 1'b1;
					end
					left_v = left_v - 1'b1;
					if (left_v == '0) begin
						if (eff_v < 16'(PAYLOAD_CAPACITY)
						    && 16'(PAYLOAD_CAPACITY) - 16'(fill_v) < 16'(threshold_q)
						    && !busy_v) begin
							bank_v   = !bank_v;
							cnt_v    = fill_v;
							busy_v   = 1'b1;
							pos_v    = '0;
							esc_v    = 1'b0;
							follow_v = '0;
							sum_v    = '0;
							fill_v   = '0;
						end
						acc_v = 1'b0;
					end
				end
				MODE_TICK: begin
					if (tick_v != 16'hFFFF) begin
						tick_v = tick_v + 1'b1;
					end
					if (fill_v != '0 && tick_v > timeout_q) begin
						if (!busy_v) begin
							bank_v   = !bank_v;
							cnt_v    = fill_v;
							busy_v   = 1'b1;
							pos_v    = '0;
							esc_v    = 1'b0;
							follow_v = '0;
							sum_v    = '0;
							fill_v   = '0;
						end
						tick_v = '0;
					end
				end
				MODE_PULL: begin
					if (busy_q) begin
						push_v = 1'b1;
						if (esc_q) begin
							byte_v = follow_q;
							esc_v  = 1'b0;
							end_v  = pos_q > last;
						end else begin
							pos_v = pos_q + 1'b1;
							if (pos_q >= PW'(POS_TYPE) && pos_q < last) begin
								sum_v = sum_q + raw;
							end
							if (pos_q != '0 && (raw == DELIM_BYTE || raw == ESC_BYTE
							    || raw == XON_BYTE || raw == XOFF_BYTE)) begin
								byte_v   = ESC_BYTE;
								esc_v    = 1'b1;
								follow_v = raw ^ ESC_XOR;
							end else begin
								byte_v = raw;
								end_v  = pos_q >= last;
							end
						end
						if (end_v) begin
							busy_v = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cnt_q    <= '0;
			bank_q   <= 1'b0;
			busy_q   <= 1'b0;
			esc_q    <= 1'b0;
			acc_q    <= 1'b0;
			pos_q    <= '0;
			follow_q <= '0;
			sum_q    <= '0;
			left_q   <= '0;
			tick_q   <= '0;
		end else begin
			fill_q   <= fill_v;
			cnt_q    <= cnt_v;
			bank_q   <= bank_v;
			busy_q   <= busy_v;
			esc_q    <= esc_v;
			acc_q    <= acc_v;
			pos_q    <= pos_v;
			follow_q <= follow_v;
			sum_q    <= sum_v;
			left_q   <= left_v;
			tick_q   <= tick_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_long_q  <= 64'h0000_0000_0000_FFFF;
			dest_short_q <= 16'hFFFE;
			frame_id_q   <= 8'h00;
			radius_q     <= 8'h00;
			options_q    <= 8'h43;
			timeout_q    <= 16'd32;
			threshold_q  <= 8'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEST_LONG:  dest_long_q  <= cfg_data;
				REG_DEST_SHORT: dest_short_q <= cfg_data[15:0];
				REG_FRAME_ID:   frame_id_q   <= cfg_data[7:0];
				REG_RADIUS:     radius_q     <= cfg_data[7:0];
				REG_OPTIONS:    options_q    <= cfg_data[7:0];
				REG_TIMEOUT:    timeout_q    <= cfg_data[15:0];
				REG_THRESHOLD:  threshold_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The read port always fetches the transmit byte for the next frame position.
	assign ra = {!bank_v, AW'(pos_v - PW'(PAYLOAD_START))};

	always_ff @(posedge clk) begin
		if (we_v) begin
			mem[wa_v] <= in_byte;
		end
		rd_data_q <= mem[ra];
	end

	assign push_item.frame_end  = end_v;
	assign push_item.frame_byte = byte_v;

	rtfb_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && push_v),
		.push_item (push_item),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = out_item.frame_byte;
	assign m_axis_tlast = out_item.frame_end;

endmodule
`default_nettype wire
